// File: hdl/hbtd_pkg.sv
// Shared types and constants for the handset button debounce block.
`default_nettype none
package hbtd_pkg;

  localparam int unsigned LampW   = 8;
  localparam int unsigned GroupW  = 4;
  localparam int unsigned HoldW   = 8;
  localparam int unsigned EventN  = 5;
  localparam int unsigned EventIdxW = $clog2(EventN);

  localparam logic [HoldW-1:0]  SpeedHoldReset = 8'd50;
  localparam logic [HoldW-1:0]  DirHoldReset   = 8'd10;
  localparam logic [GroupW-1:0] GroupOff       = 4'hF;
  localparam logic [LampW-1:0]  LampsOff       = 8'hFF;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_LAMP = 2'd0;
  localparam kind_t KIND_MODE = 2'd1;
  localparam kind_t KIND_DIR  = 2'd2;

  localparam logic OP_FAST = 1'b0;
  localparam logic OP_SLOW = 1'b1;

  typedef enum logic {
    REG_SPEED_HOLD = 1'b0,
    REG_DIR_HOLD   = 1'b1
  } reg_idx_t;

  // Pending results of one accepted item. Mask bit 0 is the lamp or mode
  // result; bits 1 to 4 are the west, east, north and south events.
  typedef struct packed {
    logic              fast;
    logic [EventN-1:0] mask;
    logic [LampW-1:0]  lamps;
    logic [1:0]        mode_sel;
  } job_t;

endpackage
`default_nettype wire

// File: hdl/hbtd_update.sv
// Button debounce, lamp state and holdoff counters; builds the result job per item.
`default_nettype none
module hbtd_update
  import hbtd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_addr,
  input  wire logic [HoldW-1:0] cfg_wdata,
  input  wire logic             fire,
  input  wire logic             op,
  input  wire logic [LampW-1:0] buttons,
  output job_t                  job
);

  logic [HoldW-1:0]  speed_cfg_r, dir_cfg_r;
  logic [LampW-1:0]  prev_r, prev_nxt;
  logic [LampW-1:0]  reported_r, reported_nxt;
  logic [GroupW-1:0] speed_r, speed_nxt;
  logic [GroupW-1:0] dir_r, dir_nxt;
  logic [HoldW-1:0]  speed_hold_r, speed_hold_nxt;
  logic [HoldW-1:0]  dir_hold_r, dir_hold_nxt;

  logic [LampW-1:0]  lamps;
  logic [LampW-1:0]  diff;
  logic [GroupW-1:0] speed_cand, dir_cand;
  logic [1:0]        low_mode;

  assign lamps = {dir_r, speed_r};
  assign diff  = lamps ^ reported_r;
  assign speed_cand = speed_r ^ ~buttons[GroupW-1:0];
  assign dir_cand   = buttons[LampW-1:GroupW];

  always_comb begin
    low_mode = 2'd0;
    for (int i = GroupW - 1; i >= 0; i--) begin
      if (diff[i]) begin
        low_mode = 2'(i);
      end
    end
  end

  always_comb begin
    prev_nxt       = prev_r;
    reported_nxt   = reported_r;
    speed_nxt      = speed_r;
    dir_nxt        = dir_r;
    speed_hold_nxt = speed_hold_r;
    dir_hold_nxt   = dir_hold_r;
    if (op == OP_FAST) begin
      prev_nxt = buttons;
      if (buttons == prev_r) begin
        if (speed_hold_r == '0) begin
          if (speed_cand != speed_r) begin
            speed_nxt      = speed_cand;
            speed_hold_nxt = speed_cfg_r;
          end
        end else begin
          speed_hold_nxt = speed_hold_r - 1'b1;
        end
        if (dir_hold_r == '0) begin
          if (dir_cand != dir_r) begin
            dir_nxt      = dir_cand;
            dir_hold_nxt = dir_cfg_r;
          end
        end else begin
          dir_hold_nxt = dir_hold_r - 1'b1;
        end
      end
    end else begin
      reported_nxt = lamps;
    end
  end

  always_comb begin
    job.fast     = (op == OP_FAST);
    job.mode_sel = '0;
    if (op == OP_FAST) begin
      job.mask  = EventN'(1);
      job.lamps = {dir_nxt, speed_nxt};
    end else begin
      job.mask     = {diff[4], diff[5], diff[6], diff[7], |diff[GroupW-1:0]};
      job.lamps    = lamps;
      job.mode_sel = low_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_cfg_r  <= SpeedHoldReset;
      dir_cfg_r    <= DirHoldReset;
      prev_r       <= '0;
      reported_r   <= LampsOff;
      speed_r      <= GroupOff;
      dir_r        <= GroupOff;
      speed_hold_r <= '0;
      dir_hold_r   <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_SPEED_HOLD) begin
          speed_cfg_r <= cfg_wdata;
        end else begin
          dir_cfg_r <= cfg_wdata;
        end
      end
      if (fire) begin
        prev_r       <= prev_nxt;
        reported_r   <= reported_nxt;
        speed_r      <= speed_nxt;
        dir_r        <= dir_nxt;
        speed_hold_r <= speed_hold_nxt;
        dir_hold_r   <= dir_hold_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/hbtd_emit.sv
// Holds one item's pending results and sends one per cycle unless out_ready stalls.
`default_nettype none
module hbtd_emit
  import hbtd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             job_load,
  input  job_t                  job,
  output logic                  take_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output kind_t                 out_kind,
  output logic [LampW-1:0]      out_lamp_drive,
  output logic [1:0]            out_mode_sel,
  output logic [1:0]            out_direction,
  output logic                  out_active,
  output logic                  out_last
);

  logic [EventN-1:0]    mask_r;
  logic                 fast_r;
  logic [LampW-1:0]     lamps_r;
  logic [1:0]           msel_r;

  logic                 out_valid_r;
  kind_t                kind_r;
  logic [LampW-1:0]     lamp_r;
  logic [1:0]           osel_r;
  logic [1:0]           dir_r;
  logic                 active_r;
  logic                 last_r;

  logic [EventIdxW-1:0] idx;
  logic [EventN-1:0]    rest;
  logic                 out_load;
  kind_t                kind_nxt;
  logic [1:0]           osel_nxt;
  logic [1:0]           dir_nxt;
  logic                 active_nxt;
  logic [2:0]           lamp_bit;

  always_comb begin
    idx = '0;
    for (int i = EventN - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        idx = EventIdxW'(i);
      end
    end
  end

  assign rest       = mask_r & ~(EventN'(1) << idx);
  assign out_load   = (|mask_r) && (!out_valid_r || out_ready);
  assign take_ready = !(|mask_r) || (out_load && rest == '0);

  always_comb begin
    osel_nxt   = '0;
    dir_nxt    = '0;
    active_nxt = 1'b0;
    lamp_bit   = '0;
    if (idx == '0) begin
      if (fast_r) begin
        kind_nxt = KIND_LAMP;
      end else begin
        kind_nxt   = KIND_MODE;
        osel_nxt   = msel_r;
        lamp_bit   = {1'b0, msel_r};
        active_nxt = ~lamps_r[lamp_bit];
      end
    end else begin
      kind_nxt   = KIND_DIR;
      dir_nxt    = 2'(idx - 1'b1);
      lamp_bit   = 3'd7 - {1'b0, dir_nxt};
      active_nxt = ~lamps_r[lamp_bit];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_load) begin
        mask_r <= job.mask;
      end else if (out_load) begin
        mask_r <= rest;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      fast_r  <= job.fast;
      lamps_r <= job.lamps;
      msel_r  <= job.mode_sel;
    end
    if (out_load) begin
      kind_r   <= kind_nxt;
      lamp_r   <= lamps_r;
      osel_r   <= osel_nxt;
      dir_r    <= dir_nxt;
      active_r <= active_nxt;
      last_r   <= (rest == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_lamp_drive = lamp_r;
  assign out_mode_sel   = osel_r;
  assign out_direction  = dir_r;
  assign out_active     = active_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire

// File: hdl/handset_button_toggle_debounce_core.sv
// Top level of the handset button debounce and lamp toggle block.
// Input channel: in_op selects a fast tick (0) carrying in_buttons, an
// active-low sample, or a slow report tick (1). A fast tick updates the
// lamp state and the holdoff counters, a slow tick the report state, in
// the cycle it is accepted. A fast tick gives one lamp-drive result; a
// slow tick gives one mode result for the lowest mode lamp changed since
// the last report and one result per changed direction lamp, at most
// five, and none when nothing changed. The last result of an item has
// out_last set. The result queue sends one result per cycle while the
// receiver is ready; the next item is taken in the cycle its predecessor's
// last result moves to the output register, or when the queue is empty.
// When the receiver stalls, the output register holds its result and the
// block stops taking items once the queue cannot drain.
// Configuration writes (cfg_addr 0 speed holdoff, 1 direction holdoff)
// take effect at the next clock; the user must make them while the block
// is idle, which the block itself does not enforce. Reset restores all
// lamps to off, clears the holdoffs and the sample history, loads the
// holdoff registers with 50 and 10 and empties the result path.
`default_nettype none
module handset_button_toggle_debounce_core
  import hbtd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_addr,
  input  wire logic [HoldW-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_op,
  input  wire logic [LampW-1:0] in_buttons,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_kind,
  output logic [LampW-1:0]      out_lamp_drive,
  output logic [1:0]            out_mode_sel,
  output logic [1:0]            out_direction,
  output logic                  out_active,
  output logic                  out_last
);

  job_t job;
  logic fire;

  assign fire = in_valid && in_ready;

  hbtd_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .op        (in_op),
    .buttons   (in_buttons),
    .job       (job)
  );

  hbtd_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_load       (fire),
    .job            (job),
    .take_ready     (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_lamp_drive (out_lamp_drive),
    .out_mode_sel   (out_mode_sel),
    .out_direction  (out_direction),
    .out_active     (out_active),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

// File: tb/sv/hbtd_lamp_event_checker.sv
// Predicts and checks the lamp and event results of the handset button debounce block.
`timescale 1ns / 100ps
module hbtd_lamp_event_checker
  import hbtd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [HoldW-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             in_op,
  input  logic [LampW-1:0] in_buttons,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [1:0]       out_kind,
  input  logic [LampW-1:0] out_lamp_drive,
  input  logic [1:0]       out_mode_sel,
  input  logic [1:0]       out_direction,
  input  logic             out_active,
  input  logic             out_last,
  output int               mismatch_count,
  output int               events_due
);

  typedef struct packed {
    kind_t            kind;
    logic [LampW-1:0] lamp_drive;
    logic [1:0]       mode_sel;
    logic [1:0]       direction;
    logic             active;
    logic             last;
  } lamp_event_t;

  lamp_event_t lamp_events_due[$];
  lamp_event_t seen;
  lamp_event_t owed;

  logic [HoldW-1:0]  mode_wait_load;
  logic [HoldW-1:0]  dir_wait_load;
  logic [LampW-1:0]  last_sample;
  logic [LampW-1:0]  lamp_byte;
  logic [LampW-1:0]  shown_lamps;
  logic [GroupW-1:0] mode_lamps;
  logic [GroupW-1:0] dir_lamps;
  logic [HoldW-1:0]  mode_wait;
  logic [HoldW-1:0]  dir_wait;

  function automatic void predict_lamp_events(input logic op, input logic [LampW-1:0] smp);
    lamp_event_t       ev;
    lamp_event_t       batch[$];
    logic [LampW-1:0]  diff;
    logic [GroupW-1:0] nxt;
    int                i;
    if (op == OP_FAST) begin
      if (smp == last_sample) begin
        if (mode_wait == '0) begin
          nxt = mode_lamps ^ ~smp[GroupW-1:0];
          if (nxt != mode_lamps) begin
            mode_wait = mode_wait_load;
            mode_lamps = nxt;
          end
        end else begin
          mode_wait = mode_wait - 1'b1;
        end
        if (dir_wait == '0) begin
          nxt = smp[LampW-1:GroupW];
          if (nxt != dir_lamps) begin
            dir_wait = dir_wait_load;
            dir_lamps = nxt;
          end
        end else begin
          dir_wait = dir_wait - 1'b1;
        end
      end
      lamp_byte = {dir_lamps, mode_lamps};
      last_sample = smp;
      ev = '0;
      ev.kind = KIND_LAMP;
      ev.lamp_drive = lamp_byte;
      batch.push_back(ev);
    end else begin
      diff = lamp_byte ^ shown_lamps;
      for (i = 0; i < GroupW; i++) begin
        if (diff[i]) begin
          ev = '0;
          ev.kind = KIND_MODE;
          ev.lamp_drive = lamp_byte;
          ev.mode_sel = 2'(i);
          ev.active = ~lamp_byte[i];
          batch.push_back(ev);
          break;
        end
      end
      for (i = 0; i < GroupW; i++) begin
        if (diff[LampW-1-i]) begin
          ev = '0;
          ev.kind = KIND_DIR;
          ev.lamp_drive = lamp_byte;
          ev.direction = 2'(i);
          ev.active = ~lamp_byte[LampW-1-i];
          batch.push_back(ev);
        end
      end
      shown_lamps = lamp_byte;
    end
    if (batch.size() > 0) begin
      batch[batch.size()-1].last = 1'b1;
    end
    foreach (batch[k]) begin
      lamp_events_due.push_back(batch[k]);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mismatch_count = 0;
      mode_wait_load = SpeedHoldReset;
      dir_wait_load = DirHoldReset;
      last_sample = '0;
      lamp_byte = LampsOff;
      shown_lamps = LampsOff;
      mode_lamps = GroupOff;
      dir_lamps = GroupOff;
      mode_wait = '0;
      dir_wait = '0;
      lamp_events_due.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_SPEED_HOLD: mode_wait_load = cfg_wdata;
          REG_DIR_HOLD:   dir_wait_load = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen = {out_kind, out_lamp_drive, out_mode_sel, out_direction, out_active, out_last};
        if (lamp_events_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"Unexpected result transfer: kind %0d lamps %h mode %0d",
                      " dir %0d act %0d last %0d"},
                     seen.kind, seen.lamp_drive, seen.mode_sel, seen.direction,
                     seen.active, seen.last);
          end
        end else begin
          owed = lamp_events_due.pop_front();
          if (seen !== owed) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display({"Result mismatch at %0t: expected kind %0d lamps %h mode %0d",
                        " dir %0d act %0d last %0d"},
                       $realtime, owed.kind, owed.lamp_drive, owed.mode_sel,
                       owed.direction, owed.active, owed.last);
              $display("  actual kind %0d lamps %h mode %0d dir %0d act %0d last %0d",
                       seen.kind, seen.lamp_drive, seen.mode_sel, seen.direction,
                       seen.active, seen.last);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_lamp_events(in_op, in_buttons);
      end
    end
    events_due = lamp_events_due.size();
  end

endmodule

// File: tb/sv/handset_button_toggle_debounce_core_tb.sv
// Stimulus, handshake timing and verdict for the handset button debounce block.
`timescale 1ns / 100ps
module handset_button_toggle_debounce_core_tb;
  import hbtd_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int LongHold   = 300;
  localparam int PhaseItems = 75;
  localparam int PhaseN     = 6;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_addr;
  logic [HoldW-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  logic             in_op;
  logic [LampW-1:0] in_buttons;
  logic             out_valid;
  logic             out_ready;
  logic [1:0]       out_kind;
  logic [LampW-1:0] out_lamp_drive;
  logic [1:0]       out_mode_sel;
  logic [1:0]       out_direction;
  logic             out_active;
  logic             out_last;

  int mismatch_count;
  int events_due;
  int quiet_cycles = 0;
  int send_calm = 0;
  int take_calm = 0;
  int long_holds_asked = 0;
  int long_holds_done = 0;

  logic [HoldW-1:0] speed_set[PhaseN] = '{8'd0, 8'd3, 8'd0, 8'd50, 8'd0, 8'd255};
  logic [HoldW-1:0] dir_set[PhaseN]   = '{8'd0, 8'd1, 8'd0, 8'd10, 8'd255, 8'd0};

  handset_button_toggle_debounce_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_buttons     (in_buttons),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_lamp_drive (out_lamp_drive),
    .out_mode_sel   (out_mode_sel),
    .out_direction  (out_direction),
    .out_active     (out_active),
    .out_last       (out_last)
  );

  hbtd_lamp_event_checker lamp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_buttons     (in_buttons),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_lamp_drive (out_lamp_drive),
    .out_mode_sel   (out_mode_sel),
    .out_direction  (out_direction),
    .out_active     (out_active),
    .out_last       (out_last),
    .mismatch_count (mismatch_count),
    .events_due     (events_due)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_pause(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(8, 30);
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [LampW-1:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return LampW'($urandom_range(0, 255));
      1: return LampsOff;
      2: return ~(8'h01 << $urandom_range(0, 7));
      default: return ~(8'h01 << $urandom_range(0, 7)) & ~(8'h01 << $urandom_range(0, 7));
    endcase
  endfunction

  task automatic send_tick(input logic op, input logic [LampW-1:0] smp);
    int pause;
    pause = draw_pause(send_calm);
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_buttons <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (events_due != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_holdoffs(input logic [HoldW-1:0] speed, input logic [HoldW-1:0] dir);
    cfg_we <= 1'b1;
    cfg_addr <= REG_SPEED_HOLD;
    cfg_wdata <= speed;
    @(posedge clk);
    cfg_addr <= REG_DIR_HOLD;
    cfg_wdata <= dir;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int target);
    int               made;
    int               hold;
    int               pick;
    logic [LampW-1:0] smp;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(0, 9);
      smp = pick_sample();
      if (pick <= 6) begin
        hold = $urandom_range(2, 6);
        repeat (hold) send_tick(OP_FAST, smp);
        made += hold;
        if ($urandom_range(0, 1) == 0) begin
          send_tick(OP_SLOW, LampW'($urandom_range(0, 255)));
          made++;
        end
      end else if (pick == 7) begin
        send_tick(OP_FAST, smp);
        made++;
      end else if (pick == 8) begin
        send_tick(OP_SLOW, LampW'($urandom_range(0, 255)));
        made++;
      end else begin
        send_tick(OP_FAST, smp);
        send_tick(OP_FAST, smp ^ (8'h01 << $urandom_range(0, 7)));
        send_tick(OP_FAST, smp);
        send_tick(OP_FAST, smp);
        made += 4;
      end
    end
  endtask

  initial begin
    int pause;
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_holds_done < long_holds_asked) begin
        long_holds_done++;
        pause = LongHold;
      end else begin
        pause = draw_pause(take_calm);
      end
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_SPEED_HOLD;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_op <= OP_FAST;
    in_buttons <= '0;
    speed_set[2] = HoldW'($urandom_range(0, 8));
    dir_set[2] = HoldW'($urandom_range(0, 8));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero holdoffs keep both groups live on every stable sample.
    write_holdoffs(8'd0, 8'd0);
    send_tick(OP_FAST, 8'h00);
    send_tick(OP_SLOW, 8'hA5);
    send_tick(OP_SLOW, 8'h00);
    send_tick(OP_FAST, 8'hFE);
    send_tick(OP_FAST, 8'hFE);
    send_tick(OP_FAST, 8'hFE);
    send_tick(OP_SLOW, 8'hFF);
    send_tick(OP_FAST, 8'hF0);
    send_tick(OP_FAST, 8'hF0);
    send_tick(OP_SLOW, 8'h00);
    send_tick(OP_FAST, 8'h0F);
    send_tick(OP_FAST, 8'h0F);
    send_tick(OP_SLOW, 8'h3C);
    send_tick(OP_FAST, 8'hFF);
    send_tick(OP_FAST, 8'hFF);
    send_tick(OP_SLOW, 8'hFF);
    drain();

    write_holdoffs(8'd255, 8'd255);
    send_tick(OP_FAST, 8'h00);
    send_tick(OP_FAST, 8'h00);
    send_tick(OP_FAST, 8'hFF);
    send_tick(OP_FAST, 8'hFF);
    send_tick(OP_SLOW, 8'h00);
    drain();

    for (int p = 0; p < PhaseN; p++) begin
      write_holdoffs(speed_set[p], dir_set[p]);
      if (p == 2) begin
        long_holds_asked++;
        send_calm = 60;
      end
      run_random(PhaseItems);
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && events_due == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: handset_button_toggle_debounce_core.f
hdl/hbtd_pkg.sv
hdl/hbtd_update.sv
hdl/hbtd_emit.sv
hdl/handset_button_toggle_debounce_core.sv
tb/sv/hbtd_lamp_event_checker.sv
tb/sv/handset_button_toggle_debounce_core_tb.sv
